// ===== rtl/avdgh_pkg.sv =====
`default_nettype none
package avdgh_pkg;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FORMAT = 1'b0,
        CFG_VOLUME = 1'b1
    } t_cfg_reg;

    localparam logic [2:0] FMT_RESET = 3'd4;
    localparam logic [2:0] FMT_ADPCM_LAST = 3'd4;
    localparam logic [2:0] FMT_PCM16 = 3'd5;
    localparam logic [3:0] VOL_RESET = 4'd8;

    localparam logic signed [13:0] LEVEL_MAX = 14'sd2047;
    localparam logic signed [13:0] LEVEL_MIN = -14'sd2048;
    localparam logic signed [6:0] INDEX_MAX = 7'sd48;

    // ADPCM decoder state plus the PCM16 byte pairing
    typedef struct packed {
        logic signed [11:0] level;
        logic [5:0]         idx;
        logic               half;
        logic [7:0]         held;
    } t_vstate;

    // one decoded byte: one or two source samples and their repeat count
    typedef struct packed {
        logic               two;
        logic signed [15:0] raw0;
        logic signed [15:0] raw1;
        logic [4:0]         reps;
        logic [3:0]         vol;
    } t_job;

    typedef struct packed {
        logic signed [11:0] level;
        logic [5:0]         idx;
    } t_nib;

    function automatic logic [10:0] step_of(input logic [5:0] i);
        logic [10:0] s;
        case (i)
            6'd0:  s = 11'd16;   6'd1:  s = 11'd17;   6'd2:  s = 11'd19;
            6'd3:  s = 11'd21;   6'd4:  s = 11'd23;   6'd5:  s = 11'd25;
            6'd6:  s = 11'd28;   6'd7:  s = 11'd31;   6'd8:  s = 11'd34;
            6'd9:  s = 11'd37;   6'd10: s = 11'd41;   6'd11: s = 11'd45;
            6'd12: s = 11'd50;   6'd13: s = 11'd55;   6'd14: s = 11'd60;
            6'd15: s = 11'd66;   6'd16: s = 11'd73;   6'd17: s = 11'd80;
            6'd18: s = 11'd88;   6'd19: s = 11'd97;   6'd20: s = 11'd107;
            6'd21: s = 11'd118;  6'd22: s = 11'd130;  6'd23: s = 11'd143;
            6'd24: s = 11'd157;  6'd25: s = 11'd173;  6'd26: s = 11'd190;
            6'd27: s = 11'd209;  6'd28: s = 11'd230;  6'd29: s = 11'd253;
            6'd30: s = 11'd279;  6'd31: s = 11'd307;  6'd32: s = 11'd337;
            6'd33: s = 11'd371;  6'd34: s = 11'd408;  6'd35: s = 11'd449;
            6'd36: s = 11'd494;  6'd37: s = 11'd544;  6'd38: s = 11'd598;
            6'd39: s = 11'd658;  6'd40: s = 11'd724;  6'd41: s = 11'd796;
            6'd42: s = 11'd876;  6'd43: s = 11'd963;  6'd44: s = 11'd1060;
            6'd45: s = 11'd1166; 6'd46: s = 11'd1282; 6'd47: s = 11'd1411;
            default: s = 11'd1552;
        endcase
        return s;
    endfunction

    // Q16 gain, 2 dB per step, index 8 is unity
    function automatic logic [18:0] gain_of(input logic [3:0] v);
        logic [18:0] g;
        case (v)
            4'd0:  g = 19'd10387;  4'd1:  g = 19'd13076;
            4'd2:  g = 19'd16462;  4'd3:  g = 19'd20724;
            4'd4:  g = 19'd26090;  4'd5:  g = 19'd32846;
            4'd6:  g = 19'd41350;  4'd7:  g = 19'd52057;
            4'd8:  g = 19'd65536;  4'd9:  g = 19'd82505;
            4'd10: g = 19'd103868; 4'd11: g = 19'd130762;
            4'd12: g = 19'd164619; 4'd13: g = 19'd207243;
            4'd14: g = 19'd260904; default: g = 19'd328458;
        endcase
        return g;
    endfunction

    function automatic logic [4:0] reps_of(input logic [2:0] f);
        logic [4:0] r;
        case (f)
            3'd0:    r = 5'd16;
            3'd1:    r = 5'd12;
            3'd2:    r = 5'd8;
            3'd3:    r = 5'd6;
            default: r = 5'd4;
        endcase
        return r;
    endfunction

    // one ADPCM nibble: level update with saturation, index adapt with clamp
    function automatic t_nib nib_step(input logic signed [11:0] lvl,
                                      input logic [5:0] idx,
                                      input logic [3:0] code);
        logic [5:0]         ci;
        logic [10:0]        st;
        logic [12:0]        d;
        logic signed [13:0] sum;
        logic signed [6:0]  dl;
        logic signed [6:0]  ni;
        t_nib               r;
        ci = (idx > 6'(INDEX_MAX)) ? 6'(INDEX_MAX) : idx;
        st = step_of(ci);
        d = 13'(st >> 3);
        if (code[0]) d = d + 13'(st >> 2);
        if (code[1]) d = d + 13'(st >> 1);
        if (code[2]) d = d + 13'(st);
        if (code[3]) sum = 14'(lvl) - $signed({1'b0, d});
        else         sum = 14'(lvl) + $signed({1'b0, d});
        if (sum > LEVEL_MAX)      r.level = LEVEL_MAX[11:0];
        else if (sum < LEVEL_MIN) r.level = LEVEL_MIN[11:0];
        else                      r.level = sum[11:0];
        case (code[2:0])
            3'd4:    dl = 7'sd2;
            3'd5:    dl = 7'sd4;
            3'd6:    dl = 7'sd6;
            3'd7:    dl = 7'sd8;
            default: dl = -7'sd1;
        endcase
        ni = $signed({1'b0, ci}) + dl;
        if (ni > INDEX_MAX)   r.idx = 6'(INDEX_MAX);
        else if (ni < 7'sd0)  r.idx = 6'd0;
        else                  r.idx = ni[5:0];
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/avdgh_decode.sv =====
`default_nettype none
module avdgh_decode (
    input  wire avdgh_pkg::t_vstate i_st,
    input  wire logic [2:0]         i_fmt,
    input  wire logic [3:0]         i_vol,
    input  wire logic [7:0]         i_byte,
    input  wire logic               i_restart,
    output avdgh_pkg::t_vstate      o_st,
    output avdgh_pkg::t_job         o_job,
    output logic                    o_has_job
);

    avdgh_pkg::t_vstate st0;
    avdgh_pkg::t_nib    n0;
    avdgh_pkg::t_nib    n1;

    always_comb begin
        st0 = i_st;
        if (i_restart) begin
            st0 = '0;
        end
        n0 = avdgh_pkg::nib_step(st0.level, st0.idx, i_byte[3:0]);
        n1 = avdgh_pkg::nib_step(n0.level, n0.idx, i_byte[7:4]);

        o_st = st0;
        o_job.two = 1'b0;
        o_job.raw0 = '0;
        o_job.raw1 = '0;
        o_job.reps = avdgh_pkg::reps_of(i_fmt);
        o_job.vol = i_vol;
        o_has_job = 1'b1;

        unique case (i_fmt) inside
            [3'd0:avdgh_pkg::FMT_ADPCM_LAST]: begin
                o_st.level = n1.level;
                o_st.idx = n1.idx;
                o_st.half = 1'b0;
                o_st.held = i_byte;
                o_job.two = 1'b1;
                o_job.raw0 = {n0.level, 4'b0000};
                o_job.raw1 = {n1.level, 4'b0000};
            end
            avdgh_pkg::FMT_PCM16: begin
                if (!st0.half) begin
                    // high byte: hold it, nothing to emit yet
                    o_st.held = i_byte;
                    o_st.half = 1'b1;
                    o_has_job = 1'b0;
                end else begin
                    o_st.half = 1'b0;
                    o_job.raw0 = {st0.held, i_byte};
                end
            end
            default: begin
                o_st.half = 1'b0;
                o_job.raw0 = {i_byte, 8'h00};
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/adpcm_voice_decode_gain_hold_core.sv =====
`default_nettype none
// ADPCM / PCM voice decoder with Q16 gain and sample-hold repeat.
// Input channel: one raw sample-data byte per word (i_data_byte, i_restart),
// taken when i_in_valid is high and o_in_stall is low. Output channel: one
// gained sample per word (o_sample, o_last), taken when o_out_valid is high
// and i_out_stall is low. o_last marks the final word caused by a byte.
// Config: i_cfg_we with i_cfg_idx (0 = sample format, 1 = volume) and
// i_cfg_data; write only while the block is idle.
// A byte is decoded at acceptance into the job register; the gain multiply then
// loads the output register once that is empty or emits its last word, and the
// first word of the byte is valid from the output register.
// Throughput: bounded by the output side. A byte yields 32/24/16/12/8 words in
// formats 0-4, 4 words in formats 6/7, and 4 words per byte pair in format 5
// (the high byte alone yields none). The job register takes the next byte while
// the current one is still being emitted, so with no output stall and bytes
// arriving in time a new word leaves every cycle.
// Reset (synchronous, active low) sets format 4, volume 8, clears the decoder
// state and empties both registers. A stalled output word holds; once the job
// register is also full, o_in_stall rises.
module adpcm_voice_decode_gain_hold_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [7:0]                       i_data_byte,
    input  wire logic                             i_restart,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic signed [18:0]                    o_sample,
    output logic                                  o_last,
    input  wire logic                             i_cfg_we,
    input  wire logic [avdgh_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [avdgh_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic [2:0]          r_fmt;
    logic [3:0]          r_vol;
    avdgh_pkg::t_vstate  r_st;
    avdgh_pkg::t_vstate  n_st;

    // job register: decoded byte awaiting the gain stage
    logic                r_a_valid;
    avdgh_pkg::t_job     r_a;
    avdgh_pkg::t_job     n_job;
    logic                n_has_job;

    // output register: gained samples being repeated
    logic                r_b_valid;
    logic signed [18:0]  r_samp0;
    logic signed [18:0]  r_samp1;
    logic                r_b_two;
    logic [4:0]          r_b_reps;
    logic [5:0]          r_b_total;
    logic [4:0]          r_b_idx;

    logic                in_acc;
    logic                out_acc;
    logic                b_last;
    logic                a_to_b;
    logic signed [19:0]  gain;
    logic signed [35:0]  prod0;
    logic signed [35:0]  prod1;

    avdgh_decode u_decode (
        .i_st      (r_st),
        .i_fmt     (r_fmt),
        .i_vol     (r_vol),
        .i_byte    (i_data_byte),
        .i_restart (i_restart),
        .o_st      (n_st),
        .o_job     (n_job),
        .o_has_job (n_has_job)
    );

    assign b_last = ({1'b0, r_b_idx} == (r_b_total - 6'd1));
    assign out_acc = r_b_valid && !i_out_stall;
    // job moves on when the output register is empty or emits its last word
    assign a_to_b = r_a_valid && (!r_b_valid || (out_acc && b_last));
    assign o_in_stall = r_a_valid && !a_to_b;
    assign in_acc = i_in_valid && !o_in_stall;

    assign o_out_valid = r_b_valid;
    assign o_last = b_last;
    // second sample of an ADPCM byte once the first one's copies are out
    assign o_sample = (r_b_two && (r_b_idx >= r_b_reps)) ? r_samp1 : r_samp0;

    // gain: floor(raw * g / 65536), arithmetic shift of the product
    assign gain = $signed({1'b0, avdgh_pkg::gain_of(r_a.vol)});
    assign prod0 = 36'(r_a.raw0) * 36'(gain);
    assign prod1 = 36'(r_a.raw1) * 36'(gain);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= avdgh_pkg::FMT_RESET;
            r_vol <= avdgh_pkg::VOL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                avdgh_pkg::CFG_FORMAT: r_fmt <= i_cfg_data[2:0];
                default:               r_vol <= i_cfg_data[3:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (in_acc) begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_acc) begin
            r_a_valid <= n_has_job;
        end else if (a_to_b) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && n_has_job) begin
            r_a <= n_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_b_idx <= '0;
        end else if (a_to_b) begin
            r_b_valid <= 1'b1;
            r_b_idx <= '0;
        end else if (out_acc) begin
            if (b_last) begin
                r_b_valid <= 1'b0;
            end
            r_b_idx <= r_b_idx + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_to_b) begin
            r_samp0 <= prod0[34:16];
            r_samp1 <= prod1[34:16];
            r_b_two <= r_a.two;
            r_b_reps <= r_a.reps;
            r_b_total <= r_a.two ? {r_a.reps, 1'b0} : {1'b0, r_a.reps};
        end
    end

    // the repeat counter never runs past the word count of its byte
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> ({1'b0, r_b_idx} < r_b_total))
        else $error("repeat counter past end of byte");

    // word count is the repeat count, doubled for two ADPCM samples
    a_total_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> ((r_b_total == {1'b0, r_b_reps}) || (r_b_total == {r_b_reps, 1'b0})))
        else $error("word count does not match repeat count");

    // the last word of a byte with nothing queued leaves the output empty
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && b_last && !r_a_valid) |=> !o_out_valid)
        else $error("output valid after last word with no job queued");

    // a held PCM16 high byte never creates a job
    a_no_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !n_has_job) |=> !r_a_valid)
        else $error("job created by a held high byte");

endmodule
`default_nettype wire
